>>> hw/rtl/modexp_pkg.sv
// Shared constants, command and status types, and controller states for modular exponentiation.
package modexp_pkg;

  // Width of the data ports and of the configuration data
  localparam int DATA_BITS = 32;
  // Kept modulus bits and exponent bits that take part
  localparam int MOD_BITS  = 32;
  localparam int EXP_BITS  = 32;
  localparam int EXP_USE   = (EXP_BITS < DATA_BITS) ? EXP_BITS : DATA_BITS;
  // Dividend width of the shift-subtract reducer: a full product or a raw base
  localparam int PROD_BITS = (2 * MOD_BITS > DATA_BITS) ? 2 * MOD_BITS : DATA_BITS;
  localparam int CNT_BITS  = $clog2(PROD_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_BASE_END,
    ST_MUL,
    ST_RED,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture a request and start the base reduction
    logic step;       // one shift-subtract step in both reducer lanes
    logic take_base;  // latch the reduced base
    logic mul;        // load both lanes with fresh products
    logic update;     // commit square, conditionally the product, shift exponent
    logic out_load;   // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic in_exp_zero;    // exponent of the offered request is zero
    logic red_last;       // reducer is on its final step
    logic exp_rest_zero;  // no set exponent bits above the current one
    logic out_free;       // output register can take a result this cycle
  } dp_sts_t;

endpackage

>>> hw/rtl/modexp_dp.sv
// Datapath: modulus register, operand registers, two multiply/reduce lanes, output register.
module modexp_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  modexp_pkg::dp_cmd_t                    cmd,
  output modexp_pkg::dp_sts_t                    sts,
  input  logic                                   cfg_write,
  input  logic [modexp_pkg::DATA_BITS-1:0]       cfg_data,
  input  logic [modexp_pkg::DATA_BITS-1:0]       base_value,
  input  logic [modexp_pkg::DATA_BITS-1:0]       exponent,
  output logic [modexp_pkg::DATA_BITS-1:0]       power_result,
  output logic                                   out_valid,
  input  logic                                   out_stall
);
  import modexp_pkg::*;

  logic [MOD_BITS-1:0]   modulus;
  logic [MOD_BITS-1:0]   base_reg;
  logic [MOD_BITS-1:0]   acc;
  logic [EXP_USE-1:0]    exp_reg;
  logic [PROD_BITS-1:0]  prod_s;
  logic [PROD_BITS-1:0]  prod_a;
  logic [MOD_BITS-1:0]   rem_s;
  logic [MOD_BITS-1:0]   rem_a;
  logic [CNT_BITS-1:0]   cnt;
  logic [2*MOD_BITS-1:0] sq_prod;
  logic [2*MOD_BITS-1:0] ab_prod;
  logic [MOD_BITS-1:0]   rem_s_next;
  logic [MOD_BITS-1:0]   rem_a_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  function automatic logic [MOD_BITS-1:0] red_step(
    input logic [MOD_BITS-1:0] rem,
    input logic                bit_in,
    input logic [MOD_BITS-1:0] m
  );
    logic [MOD_BITS:0]   t;
    logic [MOD_BITS+1:0] diff;
    t    = {rem, bit_in};
    diff = {1'b0, t} - {2'b00, m};
    if (diff[MOD_BITS+1]) begin
      red_step = t[MOD_BITS-1:0];
    end else begin
      red_step = diff[MOD_BITS-1:0];
    end
  endfunction

  assign sq_prod    = base_reg * base_reg;
  assign ab_prod    = acc * base_reg;
  assign rem_s_next = red_step(rem_s, prod_s[PROD_BITS-1], modulus);
  assign rem_a_next = red_step(rem_a, prod_a[PROD_BITS-1], modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_BITS'(1);
    end else if (cfg_write && (cfg_data[MOD_BITS-1:0] != '0)) begin
      modulus <= cfg_data[MOD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_reg <= exponent[EXP_USE-1:0];
      prod_s  <= PROD_BITS'(base_value);
      rem_s   <= '0;
      // hold the idle lane at zero while the base is reduced
      prod_a  <= '0;
      rem_a   <= '0;
      cnt     <= '0;
      // zero exponent gives 1 outright; otherwise start from 1 mod m
      if (sts.in_exp_zero || (modulus != MOD_BITS'(1))) begin
        acc <= MOD_BITS'(1);
      end else begin
        acc <= '0;
      end
    end
    if (cmd.mul) begin
      prod_s <= PROD_BITS'(sq_prod);
      prod_a <= PROD_BITS'(ab_prod);
      rem_s  <= '0;
      rem_a  <= '0;
      cnt    <= '0;
    end
    if (cmd.step) begin
      prod_s <= prod_s << 1;
      prod_a <= prod_a << 1;
      rem_s  <= rem_s_next;
      rem_a  <= rem_a_next;
      cnt    <= cnt + CNT_BITS'(1);
    end
    if (cmd.take_base) begin
      base_reg <= rem_s;
    end
    if (cmd.update) begin
      base_reg <= rem_s;
      if (exp_reg[0]) begin
        acc <= rem_a;
      end
      exp_reg <= exp_reg >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      power_result <= DATA_BITS'(acc);
    end
  end

  assign sts.in_exp_zero   = (exponent[EXP_USE-1:0] == '0);
  assign sts.red_last      = (cnt == CNT_BITS'(PROD_BITS - 1));
  assign sts.exp_rest_zero = ((exp_reg >> 1) == '0);
  assign sts.out_free      = !out_valid || !out_stall;

  a_mod_nonzero: assert property (@(posedge clk) disable iff (rst) modulus != '0)
    else $error("modulus register holds zero");
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.step) |-> (rem_s < modulus) && (rem_a < modulus))
    else $error("reducer remainder not below modulus");
  a_acc_below_mod: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.update) |-> acc < modulus)
    else $error("running result not reduced");
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a stalled result");
  a_mul_restarts_count: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.mul) |-> cnt == '0)
    else $error("reduction count not restarted");

endmodule

>>> hw/rtl/modexp_ctrl.sv
// Controller: sequences base reduction, per-bit multiply and reduce, and result hand-off.
module modexp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  output modexp_pkg::dp_cmd_t   cmd,
  input  modexp_pkg::dp_sts_t   sts
);
  import modexp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.in_exp_zero ? ST_DONE : ST_BASE;
        end
      end
      ST_BASE: begin
        if (sts.red_last) state_next = ST_BASE_END;
      end
      ST_BASE_END: state_next = ST_MUL;
      ST_MUL:      state_next = ST_RED;
      ST_RED: begin
        if (sts.red_last) state_next = ST_UPD;
      end
      ST_UPD: begin
        state_next = sts.exp_rest_zero ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_BASE:     cmd.step      = 1'b1;
      ST_BASE_END: cmd.take_base = 1'b1;
      ST_MUL:      cmd.mul       = 1'b1;
      ST_RED:      cmd.step      = 1'b1;
      ST_UPD:      cmd.update    = 1'b1;
      ST_DONE:     cmd.out_load  = sts.out_free;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: controller plus datapath.
// Flow: a zero exponent goes from idle straight to the done state and gives 1; otherwise
//   the base is reduced, then one round runs per exponent bit up to the highest set bit.
// Requests: one at a time; the next can be taken in the cycle after the result is
//   registered, while that result may still wait at the output.
// Cost per exponent bit: a multiply state, 64 shift-subtract reduction steps and an update.
// Reset (rst, synchronous): modulus returns to 1, controller idles, no result is offered.
module modular_exponentiation (
  input  logic                               clk,
  input  logic                               rst,
  // configuration: modulus register, written when cfg_write is high and cfg_data is nonzero
  input  logic                               cfg_write,
  input  logic [modexp_pkg::DATA_BITS-1:0]   cfg_data,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [modexp_pkg::DATA_BITS-1:0]   base_value,
  input  logic [modexp_pkg::DATA_BITS-1:0]   exponent,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [modexp_pkg::DATA_BITS-1:0]   power_result
);
  import modexp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The controller walks the exponent from its least significant bit; it stops early once
  // no set bit remains, as further squarings cannot change the result.
  modexp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // The datapath reduces the base first, then squares the base and multiplies the running
  // result in two lanes side by side, each product reduced one bit per cycle.
  modexp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .base_value   (base_value),
    .exponent     (exponent),
    .power_result (power_result),
    .out_valid    (out_valid),
    .out_stall    (out_stall)
  );

endmodule
